>>> hdl/lpfb_pkg.sv
// ----------------------------------------------------------------------------
// lpfb_pkg
// Shared codes, register indexes, reset values and types of the LED PWM
// fader and breather.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfb_pkg;

	localparam int OpcodeW = 2;
	localparam int ArgW    = 8;
	localparam int DutyW   = 8;
	localparam int DivW    = 4;
	localparam int CountW  = 16;
	localparam int CfgIdxW = 3;
	localparam int CfgW    = 16;

	localparam logic [OpcodeW-1:0] OP_TICK  = 2'd0;
	localparam logic [OpcodeW-1:0] OP_FLASH = 2'd1;
	localparam logic [OpcodeW-1:0] OP_RING  = 2'd2;

	localparam logic [ArgW-1:0] RING_BREATHE = 8'd0;
	localparam logic [ArgW-1:0] RING_FIXED   = 8'd1;
	localparam logic [ArgW-1:0] RING_OFF     = 8'd2;

	localparam logic [DutyW-1:0] RING_FIXED_DUTY = 8'd60;

	localparam logic [CfgIdxW-1:0] REG_PWM_PERIOD    = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_FLASH_DUTY    = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_FADE_STEP     = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_FADE_INTERVAL = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_RING_STEP     = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_RING_HOLD_ON  = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_RING_HOLD_OFF = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_RING_PEAK     = 3'd7;

	localparam logic [DutyW-1:0]  RST_PWM_PERIOD    = 8'd100;
	localparam logic [DutyW-1:0]  RST_FLASH_DUTY    = 8'd50;
	localparam logic [DutyW-1:0]  RST_FADE_STEP     = 8'd5;
	localparam logic [DivW-1:0]   RST_FADE_INTERVAL = 4'd10;
	localparam logic [CountW-1:0] RST_RING_STEP     = 16'd1200;
	localparam logic [CountW-1:0] RST_RING_HOLD_ON  = 16'd2400;
	localparam logic [CountW-1:0] RST_RING_HOLD_OFF = 16'd6000;
	localparam logic [DutyW-1:0]  RST_RING_PEAK     = 8'd160;

	typedef enum logic [3:0] {
		BR_RAMP_UP   = 4'b0001,
		BR_HOLD_ON   = 4'b0010,
		BR_RAMP_DOWN = 4'b0100,
		BR_HOLD_OFF  = 4'b1000
	} breath_state_t;

endpackage

`default_nettype wire

>>> hdl/led_pwm_fader_breather.sv
// ----------------------------------------------------------------------------
// led_pwm_fader_breather
// Software-style PWM driver for fading direction LEDs and a breathing ring LED.
// ----------------------------------------------------------------------------
// Each beat on the input channel is one command: a pwm tick, a direction
// flash or a ring call. The block takes one beat per clock while the result
// side keeps up and answers every beat with exactly one result beat carrying
// the pin levels and the ring duty after that command. All state updates
// for a beat happen in the cycle it is accepted, in one pass of compare,
// count and subtract logic; the result register is the only stage.
// Configuration registers are written through the cfg port; the user must
// write them only while no beat is in flight; the block does not enforce it.
`default_nettype none

module led_pwm_fader_breather
	import lpfb_pkg::*;
#(
	parameter int DIRECTION_CHANNELS = 4
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0]    cfg_data,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic [OpcodeW-1:0] opcode,
	input  logic [ArgW-1:0]    argument,

	output logic               out_valid,
	input  logic               out_ready,
	output logic               up_pin,
	output logic               down_pin,
	output logic               left_pin,
	output logic               right_pin,
	output logic               ring_pin,
	output logic [DutyW-1:0]   ring_duty_now
);

	localparam int N    = DIRECTION_CHANNELS;
	localparam int PadW = (N > 4) ? N : 4;

	// configuration
	logic [DutyW-1:0]  pwm_period_q;
	logic [DutyW-1:0]  flash_duty_q;
	logic [DutyW-1:0]  fade_step_q;
	logic [DivW-1:0]   fade_interval_q;
	logic [CountW-1:0] ring_step_q;
	logic [CountW-1:0] ring_hold_on_q;
	logic [CountW-1:0] ring_hold_off_q;
	logic [DutyW-1:0]  ring_peak_q;

	// state
	logic [DutyW-1:0]  phase_q, phase_d;
	logic [DutyW-1:0]  duty_q [N];
	logic [DutyW-1:0]  duty_d [N];
	logic [DivW-1:0]   div_q [N];
	logic [DivW-1:0]   div_d [N];
	logic [DutyW-1:0]  ring_duty_q, ring_duty_d;
	breath_state_t     breath_q, breath_d;
	logic [DutyW-1:0]  level_q, level_d;
	logic [CountW-1:0] count_q, count_d;
	logic [CountW-1:0] count_inc;
	logic [N:0]        flag_q, flag_d;
	logic [N:0]        pin_q, pin_d;
	logic              wrap;
	logic              above;
	logic [PadW-1:0]   dir_pad;

	logic              accept;

	assign in_ready = !out_valid || out_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_period_q    <= RST_PWM_PERIOD;
			flash_duty_q    <= RST_FLASH_DUTY;
			fade_step_q     <= RST_FADE_STEP;
			fade_interval_q <= RST_FADE_INTERVAL;
			ring_step_q     <= RST_RING_STEP;
			ring_hold_on_q  <= RST_RING_HOLD_ON;
			ring_hold_off_q <= RST_RING_HOLD_OFF;
			ring_peak_q     <= RST_RING_PEAK;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PWM_PERIOD:    pwm_period_q    <= cfg_data[DutyW-1:0];
				REG_FLASH_DUTY:    flash_duty_q    <= cfg_data[DutyW-1:0];
				REG_FADE_STEP:     fade_step_q     <= cfg_data[DutyW-1:0];
				REG_FADE_INTERVAL: fade_interval_q <= cfg_data[DivW-1:0];
				REG_RING_STEP:     ring_step_q     <= cfg_data;
				REG_RING_HOLD_ON:  ring_hold_on_q  <= cfg_data;
				REG_RING_HOLD_OFF: ring_hold_off_q <= cfg_data;
				REG_RING_PEAK:     ring_peak_q     <= cfg_data[DutyW-1:0];
				default: ;
			endcase
		end
	end

	// tick and flash: phase, direction duties, fade dividers and pin levels
	always_comb begin
		wrap    = 1'b0;
		phase_d = phase_q;
		duty_d  = duty_q;
		div_d   = div_q;
		flag_d  = flag_q;
		pin_d   = pin_q;
		above   = 1'b0;
		if (opcode == OP_TICK) begin
			if (phase_q < pwm_period_q) begin
				phase_d = phase_q + DutyW'(1);
			end else begin
				phase_d = DutyW'(1);
				wrap    = 1'b1;
			end
			for (int i = 0; i < N; i++) begin
				if (wrap && duty_q[i] != '0) begin
					if (div_q[i] < fade_interval_q) begin
						div_d[i] = div_q[i] + DivW'(1);
					end else begin
						div_d[i]  = '0;
						duty_d[i] = (duty_q[i] > fade_step_q) ? duty_q[i] - fade_step_q : '0;
					end
				end
			end
			for (int i = 0; i < N; i++) begin
				above = phase_d > duty_d[i];
				if (above && !flag_q[i]) begin
					flag_d[i] = 1'b1;
					pin_d[i]  = 1'b1;
				end else if (!above && flag_q[i]) begin
					flag_d[i] = 1'b0;
					pin_d[i]  = 1'b0;
				end
			end
			above = phase_d > ring_duty_q;
			if (above && !flag_q[N]) begin
				flag_d[N] = 1'b1;
				pin_d[N]  = 1'b0;
			end else if (!above && flag_q[N]) begin
				flag_d[N] = 1'b0;
				pin_d[N]  = 1'b1;
			end
		end else if (opcode == OP_FLASH) begin
			for (int i = 0; i < N; i++) begin
				if (argument == (ArgW'(1) << i)) begin
					duty_d[i] = flash_duty_q;
				end
			end
		end
	end

	// ring call: fixed, off and breathing sequence
	assign count_inc = count_q + CountW'(1);

	always_comb begin
		breath_d    = breath_q;
		level_d     = level_q;
		count_d     = count_q;
		ring_duty_d = ring_duty_q;
		if (opcode == OP_RING) begin
			count_d = count_inc;
			if (argument == RING_FIXED) begin
				ring_duty_d = RING_FIXED_DUTY;
			end else if (argument == RING_OFF) begin
				ring_duty_d = '0;
			end else if (argument == RING_BREATHE) begin
				unique case (breath_q)
					BR_RAMP_UP: begin
						if (level_q < ring_peak_q) begin
							if (count_inc >= ring_step_q) begin
								count_d     = '0;
								level_d     = level_q + DutyW'(1);
								ring_duty_d = level_q + DutyW'(1);
							end
						end else begin
							breath_d = BR_HOLD_ON;
							count_d  = '0;
						end
					end
					BR_HOLD_ON: begin
						if (count_inc >= ring_hold_on_q) begin
							breath_d = BR_RAMP_DOWN;
						end
					end
					BR_RAMP_DOWN: begin
						if (level_q != '0) begin
							if (count_inc >= ring_step_q) begin
								count_d     = '0;
								level_d     = level_q - DutyW'(1);
								ring_duty_d = level_q - DutyW'(1);
							end
						end else begin
							breath_d = BR_HOLD_OFF;
							count_d  = '0;
						end
					end
					BR_HOLD_OFF: begin
						if (count_inc >= ring_hold_off_q) begin
							breath_d = BR_RAMP_UP;
						end
					end
					default: breath_d = BR_RAMP_UP;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			duty_q      <= '{default: '0};
			div_q       <= '{default: '0};
			ring_duty_q <= '0;
			breath_q    <= BR_RAMP_UP;
			level_q     <= '0;
			count_q     <= '0;
			flag_q      <= '0;
			pin_q       <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			duty_q      <= duty_d;
			div_q       <= div_d;
			ring_duty_q <= ring_duty_d;
			breath_q    <= breath_d;
			level_q     <= level_d;
			count_q     <= count_d;
			flag_q      <= flag_d;
			pin_q       <= pin_d;
		end
	end

	// result beat
	assign dir_pad = PadW'(pin_d[N-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (accept) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			up_pin        <= dir_pad[0];
			down_pin      <= dir_pad[1];
			left_pin      <= dir_pad[2];
			right_pin     <= dir_pad[3];
			ring_pin      <= pin_d[N];
			ring_duty_now <= ring_duty_d;
		end
	end

	// checks
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	a_dir_pin_tracks_flag: assert property (@(posedge clk) disable iff (!arst_n)
		pin_q[N-1:0] == flag_q[N-1:0])
		else $error("direction pin out of step with its compare flag");

	a_phase_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		accept && opcode == OP_TICK |=> phase_q != '0)
		else $error("phase zero after a tick");

	a_ring_duty_reported: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ring_duty_now == ring_duty_q)
		else $error("reported ring duty differs from state");

endmodule

`default_nettype wire

>>> sim/tb_led_pwm_fader_breather.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_pwm_fader_breather
// Self-checking bench for the LED PWM fader and breather. A class predicts the
// pin levels and the ring duty after every command beat and checks each result
// beat in order. Both handshake sides stall at random. The run walks through
// several register settings, the extremes among them, with directed commands
// first and random command streams after.
// ----------------------------------------------------------------------------

module tb_led_pwm_fader_breather;
	import lpfb_pkg::*;

	localparam int NCH             = 4;
	localparam int PHASES          = 8;
	localparam int BEATS_PER_PHASE = 154;
	localparam int IDLE_LIMIT      = 500;
	localparam logic [OpcodeW-1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic             up;
		logic             down;
		logic             left;
		logic             right;
		logic             ring;
		logic [DutyW-1:0] duty;
	} pin_report_t;

	class fader_predictor;
		logic [DutyW-1:0]  period, flash_lvl, fade_dec, peak;
		logic [DivW-1:0]   fade_every;
		logic [CountW-1:0] ramp_every, hold_hi, hold_lo;
		logic [DutyW-1:0]  phase_cnt, ring_lvl, breath_lvl;
		logic [DutyW-1:0]  dir_duty[NCH];
		logic [DivW-1:0]   fade_div[NCH];
		logic [CountW-1:0] breath_cnt;
		breath_state_t     bstate;
		logic [NCH:0]      above, pins;
		pin_report_t       expected_levels[$];
		int                mismatches;

		function new();
			period     = RST_PWM_PERIOD;
			flash_lvl  = RST_FLASH_DUTY;
			fade_dec   = RST_FADE_STEP;
			fade_every = RST_FADE_INTERVAL;
			ramp_every = RST_RING_STEP;
			hold_hi    = RST_RING_HOLD_ON;
			hold_lo    = RST_RING_HOLD_OFF;
			peak       = RST_RING_PEAK;
			phase_cnt  = '0;
			ring_lvl   = '0;
			breath_lvl = '0;
			breath_cnt = '0;
			bstate     = BR_RAMP_UP;
			above      = '0;
			pins       = '0;
			mismatches = 0;
			foreach (dir_duty[i]) begin
				dir_duty[i] = '0;
				fade_div[i] = '0;
			end
		endfunction

		function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
			case (idx)
			REG_PWM_PERIOD:    period     = val[DutyW-1:0];
			REG_FLASH_DUTY:    flash_lvl  = val[DutyW-1:0];
			REG_FADE_STEP:     fade_dec   = val[DutyW-1:0];
			REG_FADE_INTERVAL: fade_every = val[DivW-1:0];
			REG_RING_STEP:     ramp_every = val;
			REG_RING_HOLD_ON:  hold_hi    = val;
			REG_RING_HOLD_OFF: hold_lo    = val;
			REG_RING_PEAK:     peak       = val[DutyW-1:0];
			default: ;
			endcase
		endfunction

		function void pwm_tick();
			int i;
			logic [DutyW-1:0] lvl;
			logic hit;
			if (phase_cnt < period) begin
				phase_cnt = phase_cnt + 1'b1;
			end else begin
				phase_cnt = 8'd1;
				for (i = 0; i < NCH; i++) begin
					if (dir_duty[i] != '0) begin
						if (fade_div[i] < fade_every) begin
							fade_div[i] = fade_div[i] + 1'b1;
						end else begin
							fade_div[i] = '0;
							dir_duty[i] = (dir_duty[i] > fade_dec) ? dir_duty[i] - fade_dec : '0;
						end
					end
				end
			end
			// ring pin runs with inverted sense
			for (i = 0; i <= NCH; i++) begin
				if (i < NCH)
					lvl = dir_duty[i];
				else
					lvl = ring_lvl;
				hit = phase_cnt > lvl;
				if (hit && !above[i]) begin
					above[i] = 1'b1;
					pins[i]  = (i != NCH);
				end else if (!hit && above[i]) begin
					above[i] = 1'b0;
					pins[i]  = (i == NCH);
				end
			end
		endfunction

		function void ring_call(logic [ArgW-1:0] arg);
			breath_cnt = breath_cnt + 1'b1;
			if (arg == RING_FIXED) begin
				ring_lvl = RING_FIXED_DUTY;
			end else if (arg == RING_OFF) begin
				ring_lvl = '0;
			end else if (arg == RING_BREATHE) begin
				case (bstate)
				BR_RAMP_UP: begin
					if (breath_lvl < peak) begin
						if (breath_cnt >= ramp_every) begin
							breath_cnt = '0;
							breath_lvl = breath_lvl + 1'b1;
							ring_lvl   = breath_lvl;
						end
					end else begin
						bstate     = BR_HOLD_ON;
						breath_cnt = '0;
					end
				end
				BR_HOLD_ON: begin
					if (breath_cnt >= hold_hi)
						bstate = BR_RAMP_DOWN;
				end
				BR_RAMP_DOWN: begin
					if (breath_lvl > 0) begin
						if (breath_cnt >= ramp_every) begin
							breath_cnt = '0;
							breath_lvl = breath_lvl - 1'b1;
							ring_lvl   = breath_lvl;
						end
					end else begin
						bstate     = BR_HOLD_OFF;
						breath_cnt = '0;
					end
				end
				default: begin
					if (breath_cnt >= hold_lo)
						bstate = BR_RAMP_UP;
				end
				endcase
			end
		endfunction

		function void note_command(logic [OpcodeW-1:0] op, logic [ArgW-1:0] arg);
			int i;
			pin_report_t r;
			case (op)
			OP_TICK:  pwm_tick();
			OP_FLASH: begin
				for (i = 0; i < NCH; i++)
					if (arg == (8'd1 << i))
						dir_duty[i] = flash_lvl;
			end
			OP_RING:  ring_call(arg);
			default: ;
			endcase
			r.up    = pins[0];
			r.down  = pins[1];
			r.left  = pins[2];
			r.right = pins[3];
			r.ring  = pins[NCH];
			r.duty  = ring_lvl;
			expected_levels.push_back(r);
		endfunction

		function void compare_field(string name, logic [DutyW-1:0] want, logic [DutyW-1:0] got);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t mismatch on %s: expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_levels(pin_report_t got);
			pin_report_t want;
			if (expected_levels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t result beat with nothing pending: %p", $time, got);
				return;
			end
			want = expected_levels.pop_front();
			compare_field("up_pin", DutyW'(want.up), DutyW'(got.up));
			compare_field("down_pin", DutyW'(want.down), DutyW'(got.down));
			compare_field("left_pin", DutyW'(want.left), DutyW'(got.left));
			compare_field("right_pin", DutyW'(want.right), DutyW'(got.right));
			compare_field("ring_pin", DutyW'(want.ring), DutyW'(got.ring));
			compare_field("ring_duty_now", want.duty, got.duty);
		endfunction
	endclass

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgW-1:0]    cfg_data  = '0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic [OpcodeW-1:0] opcode    = OP_TICK;
	logic [ArgW-1:0]    argument  = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               up_pin, down_pin, left_pin, right_pin, ring_pin;
	logic [DutyW-1:0]   ring_duty_now;

	fader_predictor board = new();
	bit rush = 1'b0;
	int idle_cycles = 0;

	led_pwm_fader_breather #(
		.DIRECTION_CHANNELS(NCH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.argument(argument),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.up_pin(up_pin),
		.down_pin(down_pin),
		.left_pin(left_pin),
		.right_pin(right_pin),
		.ring_pin(ring_pin),
		.ring_duty_now(ring_duty_now)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int draw_wait();
		return rush ? 0 : $urandom_range(0, 8);
	endfunction

	task automatic send_beat(logic [OpcodeW-1:0] op, logic [ArgW-1:0] arg);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		argument <= arg;
		do @(posedge clk); while (in_ready !== 1'b1);
		board.note_command(op, arg);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (board.expected_levels.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		board.set_reg(idx, val);
	endtask

	task automatic configure(int p);
		logic [CfgW-1:0] per, fl, stp, ivl, rstep, hon, hoff, pk;
		case (p)
		1: begin
			per = 16'd1; fl = 16'd255; stp = 16'd1; ivl = 16'd0;
			rstep = 16'd1; hon = 16'd0; hoff = 16'd0; pk = 16'd255;
		end
		2: begin
			per = 16'd255; fl = 16'd0; stp = 16'd255; ivl = 16'd15;
			rstep = 16'hFFFF; hon = 16'hFFFF; hoff = 16'hFFFF; pk = 16'd0;
		end
		// zero period and zero ring step
		3: begin
			per = 16'd0; fl = CfgW'($urandom_range(1, 255)); stp = CfgW'($urandom_range(1, 255));
			ivl = CfgW'($urandom_range(0, 15)); rstep = 16'd0; hon = 16'd3; hoff = 16'd2;
			pk = 16'd6;
		end
		default: begin
			per   = CfgW'($urandom_range(1, 12));
			fl    = CfgW'($urandom_range(0, 255));
			stp   = CfgW'($urandom_range(1, 60));
			ivl   = CfgW'($urandom_range(0, 15));
			rstep = CfgW'($urandom_range(1, 4));
			hon   = CfgW'($urandom_range(0, 10));
			hoff  = CfgW'($urandom_range(0, 10));
			pk    = CfgW'($urandom_range(1, 12));
		end
		endcase
		write_reg(REG_PWM_PERIOD, per);
		write_reg(REG_FLASH_DUTY, fl);
		write_reg(REG_FADE_STEP, stp);
		write_reg(REG_FADE_INTERVAL, ivl);
		write_reg(REG_RING_STEP, rstep);
		write_reg(REG_RING_HOLD_ON, hon);
		write_reg(REG_RING_HOLD_OFF, hoff);
		write_reg(REG_RING_PEAK, pk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : result_side
		int stall;
		pin_report_t got;
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			got.up    = up_pin;
			got.down  = down_pin;
			got.left  = left_pin;
			got.right = right_pin;
			got.ring  = ring_pin;
			got.duty  = ring_duty_now;
			board.check_levels(got);
		end
	end

	initial begin : stimulus
		int done, roll, ring_bias, beat_no;
		bit counts;
		logic [OpcodeW-1:0] op;
		logic [ArgW-1:0] arg;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: spare opcode, every flash code, bad codes, ring arguments
		send_beat(OP_SPARE, 8'd0);
		send_beat(OP_SPARE, 8'd255);
		send_beat(OP_TICK, 8'd0);
		send_beat(OP_TICK, 8'd255);
		send_beat(OP_FLASH, 8'd1);
		send_beat(OP_FLASH, 8'd2);
		send_beat(OP_FLASH, 8'd4);
		send_beat(OP_FLASH, 8'd8);
		send_beat(OP_FLASH, 8'd0);
		send_beat(OP_FLASH, 8'd3);
		send_beat(OP_FLASH, 8'd16);
		send_beat(OP_FLASH, 8'd255);
		send_beat(OP_TICK, 8'd0);
		send_beat(OP_RING, RING_FIXED);
		send_beat(OP_TICK, 8'd0);
		send_beat(OP_RING, RING_OFF);
		send_beat(OP_TICK, 8'd0);
		send_beat(OP_RING, RING_BREATHE);
		send_beat(OP_RING, 8'd3);
		send_beat(OP_RING, 8'd255);
		send_beat(OP_TICK, 8'd0);

		beat_no = 0;
		for (int p = 1; p <= PHASES; p++) begin
			settle();
			configure(p);
			ring_bias = $urandom_range(15, 55);
			done = 0;
			while (done < BEATS_PER_PHASE) begin
				if (beat_no % 64 == 0)
					rush = ($urandom_range(0, 2) == 0);
				beat_no++;
				roll = $urandom_range(0, 99);
				counts = 1'b1;
				if (roll < ring_bias) begin
					op = OP_RING; arg = RING_BREATHE;
				end else if (roll < ring_bias + 4) begin
					op = OP_RING; arg = $urandom_range(0, 1) ? RING_FIXED : RING_OFF;
				end else if (roll < ring_bias + 6) begin
					op = OP_RING; arg = ArgW'($urandom_range(0, 255));
				end else if (roll < ring_bias + 16) begin
					op = OP_FLASH; arg = 8'd1 << $urandom_range(0, NCH - 1);
				end else if (roll < ring_bias + 19) begin
					op = OP_FLASH; arg = ArgW'($urandom_range(0, 255)); counts = 1'b0;
				end else if (roll < ring_bias + 21) begin
					op = OP_SPARE; arg = ArgW'($urandom_range(0, 255)); counts = 1'b0;
				end else begin
					op = OP_TICK; arg = ArgW'($urandom_range(0, 255));
				end
				send_beat(op, arg);
				if (counts)
					done++;
				// occasional full drain mid stream
				if ($urandom_range(0, 149) == 0)
					settle();
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (board.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
